// File: rtl/tpac_pkg.sv
package tpac_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned LIMIT_W    = 15;
	localparam int unsigned PROD_W     = SAMPLE_W + LIMIT_W;
	localparam int unsigned QUO_W      = LIMIT_W;
	localparam int unsigned DIV_STEPS  = 3;
	localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;
	// prep, multiply, divider setup, divider stages, output register
	localparam int unsigned LATENCY    = DIV_STAGES + 4;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_LOW    = 3'd0;
	localparam reg_idx_t REG_CENTER = 3'd1;
	localparam reg_idx_t REG_HIGH   = 3'd2;
	localparam reg_idx_t REG_LLIM   = 3'd3;
	localparam reg_idx_t REG_RLIM   = 3'd4;

	localparam logic [SAMPLE_W-1:0] LOW_RST    = 16'h0000;
	localparam logic [SAMPLE_W-1:0] CENTER_RST = 16'h8000;
	localparam logic [SAMPLE_W-1:0] HIGH_RST   = 16'hffff;
	localparam logic [QUO_W-1:0]    MAG_SAT    = 15'h7fff;

	typedef struct packed {
		logic [SAMPLE_W-1:0] low;
		logic [SAMPLE_W-1:0] center;
		logic [SAMPLE_W-1:0] high;
		logic [LIMIT_W-1:0]  left_limit;
		logic [LIMIT_W-1:0]  right_limit;
	} cfg_t;

	typedef struct packed {
		logic                neg;
		logic [SAMPLE_W-1:0] delta;
		logic [LIMIT_W-1:0]  limit;
		logic [SAMPLE_W-1:0] span;
	} prep_t;

	typedef struct packed {
		logic                neg;
		logic                zero;
		logic                sat;
		logic [SAMPLE_W-1:0] span;
		logic [SAMPLE_W-1:0] rem;
		logic [QUO_W-1:0]    dvd;
		logic [QUO_W-1:0]    quo;
	} div_t;

endpackage

// File: rtl/tpac_prep.sv
module tpac_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld,
	input  logic [tpac_pkg::SAMPLE_W-1:0] smp,
	input  tpac_pkg::cfg_t                cfg,
	output logic                          vld_s1,
	output tpac_pkg::prep_t               prep_s1
);
	import tpac_pkg::*;

	logic [SAMPLE_W-1:0] lo_clamp;
	logic [SAMPLE_W-1:0] clamped;
	logic                left;
	prep_t               nxt;

	always_comb begin
		lo_clamp  = (smp < cfg.low) ? cfg.low : smp;
		clamped   = (lo_clamp > cfg.high) ? cfg.high : lo_clamp;
		left      = clamped < cfg.center;
		nxt.neg   = !left;
		if (left) begin
			nxt.delta = cfg.center - clamped;
			nxt.limit = cfg.left_limit;
			nxt.span  = (cfg.center > cfg.low) ? cfg.center - cfg.low : '0;
		end else begin
			nxt.delta = clamped - cfg.center;
			nxt.limit = cfg.right_limit;
			nxt.span  = (cfg.high > cfg.center) ? cfg.high - cfg.center : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		prep_s1 <= nxt;
	end

endmodule

// File: rtl/tpac_mul.sv
module tpac_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_s1,
	input  tpac_pkg::prep_t prep_s1,
	output logic            vld_s3,
	output tpac_pkg::div_t  div_s3
);
	import tpac_pkg::*;

	logic                vld_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;
	logic [SAMPLE_W-1:0] span_s2;
	logic [SAMPLE_W-1:0] prod_hi;
	div_t                nxt;

	always_comb begin
		prod_hi  = prod_s2[PROD_W-1:QUO_W];
		nxt.neg  = neg_s2;
		nxt.zero = span_s2 == '0;
		// quotient would not fit in QUO_W bits
		nxt.sat  = prod_hi >= span_s2;
		nxt.span = span_s2;
		nxt.rem  = prod_hi;
		nxt.dvd  = prod_s2[QUO_W-1:0];
		nxt.quo  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(prep_s1.delta * prep_s1.limit);
		neg_s2  <= prep_s1.neg;
		span_s2 <= prep_s1.span;
		div_s3  <= nxt;
	end

endmodule

// File: rtl/tpac_div_stage.sv
module tpac_div_stage #(
	parameter int unsigned STEPS = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_i,
	input  tpac_pkg::div_t div_i,
	output logic           vld_o,
	output tpac_pkg::div_t div_o
);
	import tpac_pkg::*;

	div_t nxt;

	always_comb begin
		logic [SAMPLE_W:0]   trial;
		logic [SAMPLE_W-1:0] r;
		logic [QUO_W-1:0]    d;
		logic [QUO_W-1:0]    q;
		r = div_i.rem;
		d = div_i.dvd;
		q = div_i.quo;
		for (int i = 0; i < STEPS; i++) begin
			trial = {r, d[QUO_W-1]};
			d     = {d[QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, div_i.span}) begin
				trial = trial - {1'b0, div_i.span};
				q     = {q[QUO_W-2:0], 1'b1};
			end else begin
				q     = {q[QUO_W-2:0], 1'b0};
			end
			r = trial[SAMPLE_W-1:0];
		end
		nxt     = div_i;
		nxt.rem = r;
		nxt.dvd = d;
		nxt.quo = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		div_o <= nxt;
	end

endmodule

// File: rtl/three_point_angle_calibration.sv
// Maps one raw steering sample to a signed angle (positive left, negative right)
// from three calibration points and two limits. Fully pipelined: a sample is
// taken in every cycle that start is high (busy is always low), and its angle
// appears with a one-cycle done strobe from the output register, after prep,
// multiply, setup and a 15-bit restoring divider (5 stages of 3 quotient bits).
// Results cannot be held off, so capture angle whenever done is high.
// Calibration registers must only be written while no sample is in flight.
module three_point_angle_calibration #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tpac_pkg::SAMPLE_W-1:0] sample,
	input  logic                          wr_en,
	input  tpac_pkg::reg_idx_t            wr_index,
	input  logic [tpac_pkg::SAMPLE_W-1:0] wr_data,
	output logic                          done,
	output logic signed [tpac_pkg::ANGLE_W-1:0] angle
);
	import tpac_pkg::*;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

	cfg_t                cfg_q;
	logic                vld_s1;
	prep_t               prep_s1;
	logic                vld_s3;
	div_t                div_s3;
	logic                dvld [DIV_STAGES+1];
	div_t                ddat [DIV_STAGES+1];
	div_t                last;
	logic [QUO_W-1:0]    mag;
	logic [ANGLE_W-1:0]  mag_ext;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low         <= LOW_RST;
			cfg_q.center      <= CENTER_RST;
			cfg_q.high        <= HIGH_RST;
			cfg_q.left_limit  <= '0;
			cfg_q.right_limit <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LOW:    cfg_q.low         <= wr_data;
				REG_CENTER: cfg_q.center      <= wr_data;
				REG_HIGH:   cfg_q.high        <= wr_data;
				REG_LLIM:   cfg_q.left_limit  <= wr_data[LIMIT_W-1:0];
				REG_RLIM:   cfg_q.right_limit <= wr_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	tpac_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start && !busy),
		.smp     (sample & SAMPLE_MASK),
		.cfg     (cfg_q),
		.vld_s1  (vld_s1),
		.prep_s1 (prep_s1)
	);

	tpac_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.prep_s1 (prep_s1),
		.vld_s3  (vld_s3),
		.div_s3  (div_s3)
	);

	assign dvld[0] = vld_s3;
	assign ddat[0] = div_s3;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		tpac_div_stage #(
			.STEPS (DIV_STEPS)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (dvld[g]),
			.div_i  (ddat[g]),
			.vld_o  (dvld[g+1]),
			.div_o  (ddat[g+1])
		);
	end

	always_comb begin
		last = ddat[DIV_STAGES];
		if (last.zero) begin
			mag = '0;
		end else if (last.sat) begin
			mag = MAG_SAT;
		end else begin
			mag = last.quo;
		end
		mag_ext = ANGLE_W'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvld[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		angle <= last.neg ? -mag_ext : mag_ext;
	end

endmodule

// File: rtl/tpac_checker.sv
module tpac_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [tpac_pkg::ANGLE_W-1:0]  angle
);
	import tpac_pkg::*;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transfer lost");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without transfer");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> angle != {1'b1, {(ANGLE_W-1){1'b0}}})
		else $error("angle out of range");

endmodule

bind three_point_angle_calibration tpac_checker u_tpac_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.angle  (angle)
);
